@@ src/dlcm_pkg.sv @@
package dlcm_pkg;

   localparam int CHAR_W  = 8;
   localparam int LEVEL_W = 16;
   localparam int WIN_W   = 7;
   localparam int WL_W    = 2;
   localparam int MASK_W  = 7;
   localparam int CODE_W  = 15;
   localparam int CNT_W   = 7;
   localparam int CNT_MAX = 127;

   localparam logic [1:0] CSR_DUST_LEVEL  = 2'd0;
   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [1:0] CSR_WORD_LENGTH = 2'd2;
   localparam logic [1:0] CSR_MASK_CHAR   = 2'd3;

   localparam logic [LEVEL_W-1:0] RESET_LEVEL = 16'd20;
   localparam logic [WIN_W-1:0]   RESET_WIN   = 7'd64;
   localparam logic [WL_W-1:0]    RESET_WL    = 2'd3;
   localparam logic [MASK_W-1:0]  RESET_MASK  = 7'd78;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TAKE, ST_SUFFIX, ST_CHAR, ST_SEARCH, ST_UPDATE,
      ST_DIV, ST_NEXTCH, ST_MASK_CARRY, ST_MASK_BEST, ST_EMIT, ST_SHIFT
   } state_type;

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic is_base(input logic [CHAR_W-1:0] c);
      unique case (c)
         8'd65, 8'd67, 8'd71, 8'd84, 8'd85,
         8'd97, 8'd99, 8'd103, 8'd116, 8'd117: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

endpackage

@@ src/dlcm_front.sv @@
module dlcm_front
   import dlcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_in_char,
   input  logic              req_in_last,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_pop
);
   // two-entry queue between channel and engine
   item_type   slot_ff [2];
   item_type   slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[0];

   always_comb begin
      item_type nw;
      nw.ch   = req_in_char;
      nw.last = req_in_last;
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (q_pop && q_valid) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_ff - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = nw;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end
endmodule

@@ src/dlcm_div.sv @@
module dlcm_div #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   // restoring divider, one quotient bit per cycle
   localparam int CW = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [CW-1:0]    n_ff, n_in;
   logic             busy_ff, busy_in;

   always_comb begin
      logic [DEN_W:0] t;
      t       = '0;
      q_in    = q_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in = num; r_in = '0; n_in = CW'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         t = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
         if (t >= {1'b0, den}) begin
            r_in = t - {1'b0, den};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = t;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   assign done = busy_ff && (n_ff == CW'(1));
   assign quo  = q_in;

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      n_ff <= n_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end
endmodule

@@ src/dlcm_back.sv @@
module dlcm_back
   import dlcm_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   input  logic [LEVEL_W-1:0] dust_level,
   input  logic [WIN_W-1:0]   window_size,
   input  logic [WL_W-1:0]    word_length,
   input  logic [MASK_W-1:0]  mask_char,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_run_last,
   output logic               rsp_seq_end
);
   localparam int AW  = $clog2(MAX_WINDOW);
   localparam int HW  = AW + 1;
   localparam int SW  = HW + 1;
   localparam int NW  = CNT_W + 2 * HW + 4;
   localparam logic [HW:0] WRAP = (HW+1)'(MAX_WINDOW);

   state_type st_ff, st_in;

   // ring is circular from head_ff; reads are registered, so data comes back in the cycle after the address
   logic [CHAR_W-1:0] ring [MAX_WINDOW];
   logic [CODE_W-1:0] codes [MAX_WINDOW];
   logic [CNT_W-1:0]  cnts [MAX_WINDOW];
   logic [CHAR_W-1:0] ring_rd_ff;
   logic [CODE_W-1:0] code_rd_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic [AW-1:0]     ring_ra, tab_ra;

   logic [HW-1:0] head_ff, head_in;
   logic [HW-1:0] held_ff, held_in;
   logic          last_ff, last_in;
   logic [HW-1:0] len_ff, len_in;
   logic [HW-1:0] t_ff, t_in;
   logic [HW-1:0] j_ff, j_in;
   logic [HW-1:0] k_ff, k_in;
   logic [HW-1:0] dc_ff, dc_in;
   logic [1:0]    run_ff, run_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [NW-1:0] sum_ff, sum_in;
   logic [LEVEL_W-1:0] bs_ff, bs_in;
   logic [HW-1:0] bst_ff, bst_in, ben_ff, ben_in;
   logic signed [SW:0] cf_ff, cf_in, ct_ff, ct_in;
   logic signed [SW:0] mj_ff, mj_in;
   logic [HW-1:0] e_ff, e_in;
   logic [HW-1:0] x_ff, x_in;
   logic [CNT_W-1:0] kc_ff, kc_in;
   logic [CHAR_W-1:0] oc_ff, oc_in;
   logic ov_ff, ov_in, ol_ff, ol_in, oe_ff, oe_in;

   logic              wr_ring, wr_code, wr_cnt;
   logic [AW-1:0]     wr_ring_a, wr_code_a, wr_cnt_a;
   logic [CHAR_W-1:0] wr_ring_d;
   logic [CNT_W-1:0]  wr_cnt_d;

   logic              div_start, div_done;
   logic [NW-1:0]     div_num, div_quo;

   logic [HW-1:0] win, w2;
   logic [WL_W-1:0] wl;
   logic out_free;

   function automatic logic [AW-1:0] phys(input logic [HW-1:0] base,
                                          input logic [HW-1:0] off);
      logic [HW:0] s;
      s = {1'b0, base} + {1'b0, off};
      if (s >= WRAP) s = s - WRAP;
      return AW'(s);
   endfunction

   dlcm_div #(.NUM_W(NW), .DEN_W(HW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(j_ff), .done(div_done), .quo(div_quo)
   );

   always_comb begin
      win = HW'(MAX_WINDOW);
      if ({1'b0, window_size} < 8'd2) win = HW'(2);
      else if (HW'(window_size) < HW'(MAX_WINDOW) && (WIN_W <= HW ||
               window_size < WIN_W'(MAX_WINDOW)))
         win = HW'(window_size);
      w2 = win >> 1;
      wl = (word_length == '0) ? WL_W'(1) : word_length;
   end

   assign out_free = !ov_ff || !rsp_stall;
   assign rsp_valid = ov_ff;
   assign rsp_out_char = oc_ff;
   assign rsp_run_last = ol_ff;
   assign rsp_seq_end = oe_ff;

   always_comb begin
      logic [CODE_W-1:0] cc;
      logic [7:0] lc;
      logic [NW-1:0] ns;
      logic signed [SW:0] lim;
      st_in = st_ff; held_in = held_ff; last_in = last_ff; len_in = len_ff;
      t_in = t_ff; j_in = j_ff; k_in = k_ff; dc_in = dc_ff; run_in = run_ff;
      code_in = code_ff; sum_in = sum_ff; bs_in = bs_ff; bst_in = bst_ff;
      ben_in = ben_ff; cf_in = cf_ff; ct_in = ct_ff; mj_in = mj_ff;
      e_in = e_ff; x_in = x_ff; kc_in = kc_ff; head_in = head_ff;
      oc_in = oc_ff; ov_in = ov_ff && rsp_stall; ol_in = ol_ff; oe_in = oe_ff;
      q_pop = 1'b0; wr_ring = 1'b0; wr_ring_a = '0; wr_ring_d = '0;
      wr_code = 1'b0; wr_code_a = '0; wr_cnt = 1'b0; wr_cnt_a = '0;
      wr_cnt_d = '0;
      div_start = 1'b0; div_num = '0;
      cc = '0; lc = '0; ns = '0; lim = '0;
      unique case (st_ff)
         ST_IDLE: if (q_valid) st_in = ST_TAKE;
         ST_TAKE: begin
            q_pop = 1'b1;
            last_in = q_item.last;
            if (held_ff < HW'(MAX_WINDOW)) begin
               wr_ring = 1'b1; wr_ring_a = phys(head_ff, held_ff);
               wr_ring_d = q_item.ch;
               held_in = held_ff + 1'b1;
            end
            st_in = ST_SUFFIX;
            t_in = '0;
            bs_in = '0; bst_in = '0; ben_in = '0;
            len_in = '0;
            // decide whether a step runs; held_in considered
            if (q_item.last ? (held_in != '0) : (held_in >= win)) begin
               len_in = (held_in < win) ? held_in : win;
               if ((len_in + 1'b1) < HW'(wl)) ben_in = (len_in != '0) ? len_in - 1'b1 : '0;
            end else begin
               st_in = ST_IDLE;
               if (q_item.last) begin cf_in = '0; ct_in = '1; end
            end
         end
         ST_SUFFIX: begin
            if ((t_ff + HW'(wl)) < (len_ff + 1'b1)) begin
               j_in = '0; run_in = '0; code_in = '0; sum_in = '0; dc_in = '0;
               st_in = ST_CHAR;
            end else begin
               mj_in = cf_ff;
               st_in = ST_MASK_CARRY;
            end
         end
         ST_CHAR: begin
            if (j_ff >= len_ff - t_ff) begin
               t_in = t_ff + 1'b1;
               st_in = ST_SUFFIX;
            end else begin
               cc = (code_ff << 5);
               if (!is_letter(ring_rd_ff)) begin
                  code_in = cc; run_in = '0; st_in = ST_NEXTCH;
               end else begin
                  lc = (ring_rd_ff >= 8'd97) ? ring_rd_ff - 8'd97 : ring_rd_ff - 8'd65;
                  code_in = cc | CODE_W'(lc[4:0]);
                  run_in = (run_ff == 2'd3) ? 2'd3 : run_ff + 1'b1;
                  if (((run_ff == 2'd3) ? 2'd3 : run_ff + 1'b1) < wl)
                     st_in = ST_NEXTCH;
                  else begin k_in = '0; st_in = ST_SEARCH; end
               end
            end
         end
         ST_SEARCH: begin
            // one table entry per cycle
            if (k_ff == dc_ff) begin
               if (dc_ff >= HW'(MAX_WINDOW)) st_in = ST_NEXTCH;
               else begin
                  wr_code = 1'b1; wr_code_a = AW'(k_ff);
                  dc_in = dc_ff + 1'b1;
                  kc_in = '0;
                  st_in = ST_UPDATE;
               end
            end else if (code_rd_ff == code_ff) begin
               kc_in = cnt_rd_ff;
               st_in = ST_UPDATE;
            end else k_in = k_ff + 1'b1;
         end
         ST_UPDATE: begin
            wr_cnt = 1'b1; wr_cnt_a = AW'(k_ff);
            wr_cnt_d = (kc_ff < CNT_W'(CNT_MAX)) ? kc_ff + 1'b1 : kc_ff;
            if (kc_ff != '0 && j_ff != '0) begin
               ns = sum_ff + NW'(kc_ff);
               sum_in = ns;
               div_start = 1'b1;
               div_num = NW'((ns << 3) + (ns << 1));
               st_in = ST_DIV;
            end else st_in = ST_NEXTCH;
         end
         ST_DIV: if (div_done) begin
            if (NW'(bs_ff) < div_quo) begin
               bs_in = LEVEL_W'(div_quo);
               bst_in = t_ff; ben_in = t_ff + j_ff;
            end
            st_in = ST_NEXTCH;
         end
         ST_NEXTCH: begin j_in = j_ff + 1'b1; st_in = ST_CHAR; end
         ST_MASK_CARRY: begin
            if (mj_ff <= ct_ff) begin
               if (mj_ff >= 0 && mj_ff < $signed({2'b0, held_ff}) &&
                   is_base(ring_rd_ff)) begin
                  wr_ring = 1'b1; wr_ring_a = phys(head_ff, HW'(mj_ff));
                  wr_ring_d = {1'b0, mask_char};
               end
               mj_in = mj_ff + 1'b1;
            end else if ({{(NW-LEVEL_W){1'b0}}, bs_ff} > NW'(dust_level)) begin
               mj_in = $signed({2'b0, bst_ff});
               st_in = ST_MASK_BEST;
            end else begin
               cf_in = '0; ct_in = '1;
               e_in = (held_ff < w2) ? held_ff : w2; x_in = '0;
               st_in = ST_EMIT;
            end
         end
         ST_MASK_BEST: begin
            lim = $signed({2'b0, w2});
            if (mj_ff <= $signed({2'b0, ben_ff}) && mj_ff < lim) begin
               if (mj_ff < $signed({2'b0, held_ff}) && is_base(ring_rd_ff)) begin
                  wr_ring = 1'b1; wr_ring_a = phys(head_ff, HW'(mj_ff));
                  wr_ring_d = {1'b0, mask_char};
               end
               mj_in = mj_ff + 1'b1;
            end else begin
               cf_in = mj_ff - lim;
               ct_in = $signed({2'b0, ben_ff}) - lim;
               e_in = (held_ff < w2) ? held_ff : w2; x_in = '0;
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (x_ff == e_ff) st_in = ST_SHIFT;
            else if (out_free) begin
               ov_in = 1'b1; oc_in = ring_rd_ff;
               ol_in = 1'b0; oe_in = 1'b0;
               // last char of the whole response burst
               if (x_ff + 1'b1 == e_ff && (held_ff == e_ff ? last_ff :
                   (!last_ff && held_ff - e_ff < win))) begin
                  ol_in = 1'b1; oe_in = last_ff;
               end
               x_in = x_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            head_in = HW'(phys(head_ff, e_ff));
            held_in = held_ff - e_ff;
            t_in = '0; bs_in = '0; bst_in = '0; ben_in = '0;
            if (last_ff ? (held_in != '0) : (held_in >= win)) begin
               len_in = (held_in < win) ? held_in : win;
               if ((len_in + 1'b1) < HW'(wl)) ben_in = (len_in != '0) ? len_in - 1'b1 : '0;
               st_in = ST_SUFFIX;
            end else begin
               if (last_ff) begin cf_in = '0; ct_in = '1; end
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // read addresses follow the next state so data is ready when it is used
   always_comb begin
      logic [HW-1:0] roff;
      roff = x_in;
      if (st_in == ST_CHAR) roff = t_in + j_in;
      else if (st_in == ST_MASK_CARRY || st_in == ST_MASK_BEST) roff = HW'(mj_in);
      ring_ra = phys(head_ff, roff);
      tab_ra  = AW'(k_in);
   end

   always_ff @(posedge clock) begin
      if (wr_ring) ring[wr_ring_a] <= wr_ring_d;
      ring_rd_ff <= ring[ring_ra];
   end

   always_ff @(posedge clock) begin
      if (wr_code) codes[wr_code_a] <= code_ff;
      code_rd_ff <= codes[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (wr_cnt) cnts[wr_cnt_a] <= wr_cnt_d;
      cnt_rd_ff <= cnts[tab_ra];
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in; t_ff <= t_in; j_ff <= j_in; k_ff <= k_in;
      dc_ff <= dc_in; run_ff <= run_in; code_ff <= code_in; sum_ff <= sum_in;
      bs_ff <= bs_in; bst_ff <= bst_in; ben_ff <= ben_in; mj_ff <= mj_in;
      e_ff <= e_in; x_ff <= x_in; kc_ff <= kc_in;
      oc_ff <= oc_in; ol_ff <= ol_in; oe_ff <= oe_in; last_ff <= last_in;
      if (reset) begin
         st_ff <= ST_IDLE; held_ff <= '0; head_ff <= '0; cf_ff <= '0; ct_ff <= '1;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; held_ff <= held_in; head_ff <= head_in; cf_ff <= cf_in;
         ct_ff <= ct_in; ov_ff <= ov_in;
      end
   end
endmodule

@@ src/dust_low_complexity_masker.sv @@
// dust low-complexity masker
// req channel: one ascii character per transfer (req_in_char) with
// req_in_last on the final character of a sequence. rsp channel: the
// characters again, in order, with low-complexity nucleotide runs replaced
// by the mask letter; rsp_run_last marks the last character released by
// one input, rsp_seq_end the end of the sequence.
// csr port: write-only, index 0 level, 1 window, 2 word length, 3 mask.
// a two-entry queue takes characters while the scoring engine works.
// a window step scans every suffix character by character, one cycle
// per word-table entry searched, with a division for each score, then
// masks and releases its half.
// during release, results leave one per cycle unless rsp is stalled.
// reset empties the queue and the engine and restores register defaults.
// a stalled rsp holds its character; the engine waits, the queue fills and
// then req_stall rises.
module dust_low_complexity_masker
   import dlcm_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_in_char,
   input  logic              req_in_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_run_last,
   output logic              rsp_seq_end,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [LEVEL_W-1:0] csr_wdata
);
   logic [LEVEL_W-1:0] level_ff;
   logic [WIN_W-1:0]   win_ff;
   logic [WL_W-1:0]    wl_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic               q_valid, q_pop;
   item_type           q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= RESET_LEVEL; win_ff <= RESET_WIN;
         wl_ff <= RESET_WL; mask_ff <= RESET_MASK;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DUST_LEVEL:  level_ff <= csr_wdata;
            CSR_WINDOW_SIZE: win_ff <= csr_wdata[WIN_W-1:0];
            CSR_WORD_LENGTH: wl_ff <= csr_wdata[WL_W-1:0];
            CSR_MASK_CHAR:
               if (is_letter({1'b0, csr_wdata[MASK_W-1:0]}))
                  mask_ff <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   dlcm_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .req_in_char(req_in_char),
      .req_in_last(req_in_last), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop)
   );

   dlcm_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop), .dust_level(level_ff), .window_size(win_ff),
      .word_length(wl_ff), .mask_char(mask_ff), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_out_char(rsp_out_char),
      .rsp_run_last(rsp_run_last), .rsp_seq_end(rsp_seq_end)
   );

   a_end_implies_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_end |-> rsp_run_last) else $error("seq_end without run_last");
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");
   a_mask_letter: assert property (@(posedge clock) disable iff (reset)
      is_letter({1'b0, mask_ff})) else $error("mask register not a letter");
endmodule

@@ test/dust_masker_checker.sv @@
`timescale 1ns / 100ps

module dust_masker_checker
   import dlcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [CHAR_W-1:0]  req_in_char,
   input  logic               req_in_last,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [CHAR_W-1:0]  rsp_out_char,
   input  logic               rsp_run_last,
   input  logic               rsp_seq_end,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [LEVEL_W-1:0] csr_wdata,
   output int                 errors,
   output int                 pending
);

   localparam int RING_DEPTH = 64;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              run_last;
      logic              seq_end;
   } released_char_type;

   released_char_type released_q[$];

   logic [CHAR_W-1:0] seq_ring[RING_DEPTH];
   logic [CODE_W-1:0] word_codes[RING_DEPTH];
   int                word_counts[RING_DEPTH];
   int                n_words, top_score, top_start, top_end;
   int                carry_lo, carry_hi, n_held;

   logic [LEVEL_W-1:0] level_q;
   logic [WIN_W-1:0]   win_q;
   logic [WL_W-1:0]    wlen_q;
   logic [MASK_W-1:0]  mask_q;

   function automatic bit alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit nucleotide(input logic [7:0] c);
      case (c)
         "A", "C", "G", "T", "U", "a", "c", "g", "t", "u": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic int window_len();
      int w;
      w = win_q;
      if (w < 2) w = 2;
      if (w > RING_DEPTH) w = RING_DEPTH;
      return w;
   endfunction

   function automatic void score_suffix(int start, int len, int wl);
      int run, code, sum, j, k, v, c;
      run = 0;
      code = 0;
      sum = 0;
      n_words = 0;
      for (j = 0; j < len; j++) begin
         c = (start + j < RING_DEPTH) ? seq_ring[start + j] : 0;
         code = (code << 5) & 32'h7fff;
         if (!alpha(c)) begin
            run = 0;
            continue;
         end
         code = code | ((c >= "a") ? (c - "a") : (c - "A"));
         run++;
         if (run < wl) continue;
         for (k = 0; k < n_words && word_codes[k] != code; k++) ;
         if (k == n_words) begin
            if (n_words >= RING_DEPTH) continue;
            word_codes[k] = code;
            word_counts[k] = 0;
            n_words++;
         end
         if (word_counts[k] > 0 && j > 0) begin
            sum += word_counts[k];
            v = 10 * sum / j;
            if (top_score < v) begin
               top_score = v & 32'hffff;
               top_start = start;
               top_end = start + j;
            end
         end
         if (word_counts[k] < CNT_MAX) word_counts[k]++;
      end
   endfunction

   function automatic int score_window(int l);
      int wl, t;
      wl = (wlen_q != 0) ? wlen_q : 1;
      top_score = 0;
      top_start = 0;
      top_end = 0;
      if (l + 1 < wl) begin
         top_end = (l != 0) ? l - 1 : 0;
         return 0;
      end
      for (t = 0; t + wl < l + 1; t++)
         score_suffix(t, l - t, wl);
      return top_score;
   endfunction

   function automatic void mask_one(int j);
      if (j >= 0 && j < n_held && nucleotide(seq_ring[j]))
         seq_ring[j] = {1'b0, mask_q};
   endfunction

   function automatic int release_half(int n);
      int win, w2, l, v, j, e, k;
      released_char_type r;
      win = window_len();
      w2 = win / 2;
      l = (n_held < win) ? n_held : win;
      v = score_window(l);
      for (j = carry_lo; j <= carry_hi; j++)
         mask_one(j);
      if (v > level_q) begin
         for (j = top_start; j <= top_end && j < w2; j++)
            mask_one(j);
         carry_lo = j - w2;
         carry_hi = top_end - w2;
      end else begin
         carry_lo = 0;
         carry_hi = -1;
      end
      e = (n_held < w2) ? n_held : w2;
      for (k = 0; k < e; k++) begin
         r.ch = seq_ring[k];
         r.run_last = 1'b0;
         r.seq_end = 1'b0;
         released_q.insert(released_q.size(), r);
         n++;
      end
      for (k = 0; k < n_held - e; k++)
         seq_ring[k] = seq_ring[k + e];
      n_held -= e;
      return n;
   endfunction

   function automatic void take_char(logic [7:0] c, logic last);
      int n;
      n = 0;
      if (n_held < RING_DEPTH) begin
         seq_ring[n_held] = c;
         n_held++;
      end
      if (last) begin
         while (n_held > 0) n = release_half(n);
         carry_lo = 0;
         carry_hi = -1;
      end else begin
         while (n_held >= window_len()) n = release_half(n);
      end
      if (n > 0) begin
         released_q[$].run_last = 1'b1;
         if (last) released_q[$].seq_end = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      released_char_type want;
      if (reset) begin
         released_q.delete();
         for (int i = 0; i < RING_DEPTH; i++) word_counts[i] = 0;
         n_words = 0;
         top_score = 0;
         top_start = 0;
         top_end = 0;
         carry_lo = 0;
         carry_hi = -1;
         n_held = 0;
         level_q = RESET_LEVEL;
         win_q = RESET_WIN;
         wlen_q = RESET_WL;
         mask_q = RESET_MASK;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DUST_LEVEL:  level_q = csr_wdata;
               CSR_WINDOW_SIZE: win_q = csr_wdata[WIN_W-1:0];
               CSR_WORD_LENGTH: wlen_q = csr_wdata[WL_W-1:0];
               CSR_MASK_CHAR:
                  if (alpha({1'b0, csr_wdata[MASK_W-1:0]})) mask_q = csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end
         // result side first: a char released this edge cannot come from this edge's input
         if (rsp_valid && !rsp_stall) begin
            if (released_q.size() == 0) begin
               $error("unexpected rsp transfer, out_char %0d", rsp_out_char);
               errors++;
            end else begin
               want = released_q.pop_front();
               if (rsp_out_char !== want.ch) begin
                  $error("out_char expected %0d actual %0d", want.ch, rsp_out_char);
                  errors++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last expected %0d actual %0d", want.run_last, rsp_run_last);
                  errors++;
               end
               if (rsp_seq_end !== want.seq_end) begin
                  $error("seq_end expected %0d actual %0d", want.seq_end, rsp_seq_end);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) take_char(req_in_char, req_in_last);
      end
      pending = released_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import dlcm_pkg::*;

   localparam int STALL_LIMIT = 1000000;
   localparam int N_RANDOM = 160;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [CHAR_W-1:0]  req_in_char;
   logic               req_in_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [CHAR_W-1:0]  rsp_out_char;
   logic               rsp_run_last;
   logic               rsp_seq_end;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [LEVEL_W-1:0] csr_wdata;

   int errors, pending;
   int send_idle_pct, recv_stall_pct;
   int quiet_cycles;
   int n_sent;

   dust_low_complexity_masker uut (.*);

   dust_masker_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [LEVEL_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // let the engine drain before touching registers
   task automatic settle();
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_char(logic [7:0] c, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         @(posedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(3)) @(posedge clock);
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req_in_char <= c;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
      n_sent++;
      // drop valid right after the transfer
      req_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_base();
      case ($urandom_range(9))
         0: return "A"; 1: return "C"; 2: return "G"; 3: return "T"; 4: return "U";
         5: return "a"; 6: return "c"; 7: return "g"; 8: return "t";
         default: return "u";
      endcase
   endfunction

   task automatic send_seq(int len);
      logic [7:0] motif[4];
      int period, kind;
      logic [7:0] c;
      period = $urandom_range(1, 4);
      kind = $urandom_range(9);
      for (int i = 0; i < 4; i++) motif[i] = pick_base();
      for (int i = 0; i < len; i++) begin
         if (kind < 6) c = ($urandom_range(9) == 0) ? pick_base() : motif[i % period];
         else if (kind < 8) c = pick_base();
         else c = $urandom_range(255);
         if ($urandom_range(29) == 0) c = $urandom_range(255);
         send_char(c, i == len - 1);
      end
   endtask

   task automatic random_config();
      int w;
      w = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(2, 16);
      write_csr(CSR_WINDOW_SIZE, w);
      write_csr(CSR_DUST_LEVEL, ($urandom_range(9) == 0) ? 16'hffff : $urandom_range(40));
      write_csr(CSR_WORD_LENGTH, $urandom_range(3));
      write_csr(CSR_MASK_CHAR, $urandom_range(127));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_char = '0;
      req_in_last = 1'b0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_cycles = 0;
      n_sent = 0;
      send_idle_pct = 13;
      recv_stall_pct = 51;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // a partial window held, then the window shrinks while chars are held
      for (int i = 0; i < 12; i++) send_char("ACG" >> (8 * (2 - i % 3)), 1'b0);
      settle();
      write_csr(CSR_WINDOW_SIZE, 4);
      write_csr(CSR_WORD_LENGTH, 0);
      write_csr(CSR_DUST_LEVEL, 0);
      write_csr(CSR_MASK_CHAR, "a");
      write_csr(CSR_MASK_CHAR, "5");
      send_char("t", 1'b0);
      send_char(8'hc1, 1'b0);
      send_char("u", 1'b1);
      settle();
      write_csr(CSR_WINDOW_SIZE, 0);
      write_csr(CSR_DUST_LEVEL, 16'hffff);
      write_csr(CSR_MASK_CHAR, "z");
      send_char(8'hff, 1'b0);
      send_char("Z", 1'b1);
      settle();
      write_csr(CSR_WINDOW_SIZE, 1);
      write_csr(CSR_WORD_LENGTH, 3);
      write_csr(CSR_DUST_LEVEL, 0);
      write_csr(CSR_MASK_CHAR, "A");
      send_char("a", 1'b0);
      send_char(8'h00, 1'b1);
      settle();
      write_csr(CSR_WINDOW_SIZE, 127);
      write_csr(CSR_WORD_LENGTH, 2);
      send_char("g", 1'b1);
      settle();
      write_csr(CSR_WINDOW_SIZE, 100);
      write_csr(CSR_WORD_LENGTH, 1);
      send_char("C", 1'b0);
      send_char("C", 1'b1);
      settle();

      while (n_sent < N_RANDOM) begin
         if (n_sent > 2 * N_RANDOM / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else if (n_sent > N_RANDOM / 3) begin
            send_idle_pct = 51;
            recv_stall_pct = 13;
         end
         random_config();
         send_seq($urandom_range(1, 24));
         settle();
      end

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
